[rtl/string_id_dictionary_defines.svh]
// assertion macros for the string id dictionary
`ifndef STRING_ID_DICTIONARY_DEFINES_SVH
`define STRING_ID_DICTIONARY_DEFINES_SVH
`ifndef SYNTH
`define SID_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sid assertion failed");
`define SID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sid assertion failed");
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sid assertion failed");
`else
`define SID_ASSERT_NEVER(label, clk, rst_n, expr)
`define SID_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sid_pkg.sv]
// shared constants for the string id dictionary
package sid_pkg;
    localparam int STATUS_W = 3;
    localparam int SUM_W    = 16;
    localparam logic [SUM_W:0] ADLER_MOD = 17'd65521;

    // bucket count is a power of two, so the bucket is the low hash bits
    localparam int BKT_W      = 5;
    localparam int BUCKET_CNT = 1 << BKT_W;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_DUPLICATE = 3'd1;
    localparam t_status ST_FOUND     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FULL      = 3'd4;
    localparam t_status ST_TOO_LONG  = 3'd5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;
endpackage

[rtl/sid_ram.sv]
// generic single write, single read ram with registered read data
module sid_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/string_id_dictionary.sv]
// string interning dictionary: adler-32 bucket hash, chained entries in ram
//
// channel | dir | handshake                 | word
// input   | in  | i_in_valid / o_in_ready   | i_operation, i_key_byte, i_key_last
// output  | out | o_out_valid / i_out_ready | o_status, o_key_id, o_key_count
//
// a byte that is not the last is stored and summed; ready stays high while bytes arrive.
// the last byte takes the bucket from the low sum bits; S_HEAD/S_HEADW read its head,
//   then the chain walk reads entries in S_META/S_METAW and bytes in S_CMP/S_CMPW.
// an insert that adds the key copies it byte by byte in S_CPY/S_CPYW; the result then
//   waits for the output register to be free, and no byte is taken until it is loaded.
// reset (i_rst_n low, synchronous) empties all buckets at once; no clearing pass.
`include "string_id_dictionary_defines.svh"
module string_id_dictionary #(
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_KEY_BYTES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [7:0]                          i_key_byte,
    input  logic                                i_key_last,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sid_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0]  o_key_id,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0]  o_key_count
);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int PA_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int BKT_W = sid_pkg::BKT_W;
    localparam int KA_W  = $clog2(MAX_ENTRIES * MAX_KEY_BYTES);
    localparam int META_W = LEN_W + CNT_W;
    localparam logic [CNT_W-1:0] EMPTY = CNT_W'(MAX_ENTRIES);

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_HEADW = 4'd3;
    localparam logic [3:0] S_META  = 4'd4;
    localparam logic [3:0] S_METAW = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_CMPW  = 4'd7;
    localparam logic [3:0] S_CPY   = 4'd8;
    localparam logic [3:0] S_CPYW  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]                   r_state;
    logic [sid_pkg::SUM_W-1:0]    r_lo, r_hi, n_lo, n_hi;
    logic [sid_pkg::SUM_W:0]      lo_sum, hi_sum;
    logic [LEN_W-1:0]             r_len, r_klen, r_j;
    logic                         r_ovf, r_op;
    logic [BKT_W-1:0]             r_rem;
    logic [sid_pkg::BUCKET_CNT-1:0] r_bvalid;
    logic                         r_hvld;
    logic [CNT_W-1:0]             r_cur, r_next, r_head, r_count;
    sid_pkg::t_status             r_res_status;
    logic [CNT_W-1:0]             r_res_id;
    logic                         accept, j_last;
    logic                         walk_live, byte_step;

    // ram ports
    logic                         pend_we;
    logic [PA_W-1:0]              pend_raddr;
    logic [7:0]                   pend_rdata;
    logic                         key_we;
    logic [KA_W-1:0]              key_waddr, key_raddr;
    logic [7:0]                   key_rdata;
    logic                         meta_we;
    logic [META_W-1:0]            meta_rdata;
    logic                         bkt_we;
    logic [CNT_W-1:0]             bkt_rdata;

    assign o_in_ready = (r_state == S_ACC);
    assign accept     = i_in_valid && o_in_ready;
    assign j_last     = (r_j == r_klen - LEN_W'(1));
    assign walk_live  = (r_state == S_META) && (r_cur != EMPTY);
    assign byte_step  = (r_state == S_CMP) || (r_state == S_CPY);

    // running adler-32 sums, one compare and subtract each
    always_comb begin
        lo_sum = {1'b0, r_lo} + {{(sid_pkg::SUM_W - 7){1'b0}}, i_key_byte};
        n_lo   = (lo_sum >= sid_pkg::ADLER_MOD) ? sid_pkg::SUM_W'(lo_sum - sid_pkg::ADLER_MOD)
                                                : lo_sum[sid_pkg::SUM_W-1:0];
        hi_sum = {1'b0, r_hi} + {1'b0, n_lo};
        n_hi   = (hi_sum >= sid_pkg::ADLER_MOD) ? sid_pkg::SUM_W'(hi_sum - sid_pkg::ADLER_MOD)
                                                : hi_sum[sid_pkg::SUM_W-1:0];
    end

    // memory access control
    always_comb begin
        pend_we    = accept && (r_len < LEN_W'(MAX_KEY_BYTES));
        pend_raddr = r_j[PA_W-1:0];
        key_we     = (r_state == S_CPYW);
        key_waddr  = KA_W'(r_count[IDX_W-1:0]) * KA_W'(MAX_KEY_BYTES) + KA_W'(r_j);
        key_raddr  = KA_W'(r_cur[IDX_W-1:0]) * KA_W'(MAX_KEY_BYTES) + KA_W'(r_j);
        meta_we    = (r_state == S_CPYW) && j_last;
        bkt_we     = meta_we;
    end

    sid_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_pend (
        .i_clk(i_clk), .i_we(pend_we), .i_waddr(r_len[PA_W-1:0]), .i_wdata(i_key_byte),
        .i_raddr(pend_raddr), .o_rdata(pend_rdata)
    );

    sid_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES * MAX_KEY_BYTES)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(pend_rdata),
        .i_raddr(key_raddr), .o_rdata(key_rdata)
    );

    sid_ram #(.WIDTH(META_W), .DEPTH(MAX_ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata({r_klen, r_head}), .i_raddr(r_cur[IDX_W-1:0]), .o_rdata(meta_rdata)
    );

    sid_ram #(.WIDTH(CNT_W), .DEPTH(sid_pkg::BUCKET_CNT)) u_bkt (
        .i_clk(i_clk), .i_we(bkt_we), .i_waddr(r_rem), .i_wdata(r_count),
        .i_raddr(r_rem), .o_rdata(bkt_rdata)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_lo        <= sid_pkg::SUM_W'(1);
            r_hi        <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_bvalid    <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // the done state reloads the output register itself
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    if (accept) begin
                        if (i_key_last) begin
                            r_lo   <= sid_pkg::SUM_W'(1);
                            r_hi   <= '0;
                            r_len  <= '0;
                            r_ovf  <= 1'b0;
                            r_op   <= i_operation;
                            r_klen <= (r_len < LEN_W'(MAX_KEY_BYTES)) ? r_len + LEN_W'(1)
                                                                      : r_len;
                            // hash modulo bucket count keeps the low bits of the low sum
                            r_rem  <= n_lo[BKT_W-1:0];
                            if (r_ovf || r_len == LEN_W'(MAX_KEY_BYTES)) begin
                                r_res_status <= sid_pkg::ST_TOO_LONG;
                                r_res_id     <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_HEAD;
                            end
                        end else begin
                            r_lo <= n_lo;
                            r_hi <= n_hi;
                            if (r_len < LEN_W'(MAX_KEY_BYTES)) begin
                                r_len <= r_len + LEN_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                end
                S_HEAD: begin
                    r_hvld  <= r_bvalid[r_rem];
                    r_state <= S_HEADW;
                end
                S_HEADW: begin
                    r_cur   <= r_hvld ? bkt_rdata : EMPTY;
                    r_head  <= r_hvld ? bkt_rdata : EMPTY;
                    r_state <= S_META;
                end
                S_META: begin
                    if (r_cur == EMPTY) begin
                        // chain ends without a match
                        if (r_op == sid_pkg::OP_LOOKUP) begin
                            r_res_status <= sid_pkg::ST_NOT_FOUND;
                            r_res_id     <= '0;
                            r_state      <= S_DONE;
                        end else if (r_count >= EMPTY) begin
                            r_res_status <= sid_pkg::ST_FULL;
                            r_res_id     <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_CPY;
                        end
                    end else begin
                        r_state <= S_METAW;
                    end
                end
                S_METAW: begin
                    r_next <= meta_rdata[CNT_W-1:0];
                    if (meta_rdata[META_W-1:CNT_W] == r_klen) begin
                        r_j     <= '0;
                        r_state <= S_CMP;
                    end else begin
                        r_cur   <= meta_rdata[CNT_W-1:0];
                        r_state <= S_META;
                    end
                end
                S_CMP: begin
                    r_state <= S_CMPW;
                end
                S_CMPW: begin
                    if (pend_rdata != key_rdata) begin
                        r_cur   <= r_next;
                        r_state <= S_META;
                    end else if (j_last) begin
                        r_res_status <= (r_op == sid_pkg::OP_LOOKUP) ? sid_pkg::ST_FOUND
                                                                     : sid_pkg::ST_DUPLICATE;
                        r_res_id     <= r_cur + CNT_W'(1);
                        r_state      <= S_DONE;
                    end else begin
                        r_j     <= r_j + LEN_W'(1);
                        r_state <= S_CMP;
                    end
                end
                S_CPY: begin
                    r_state <= S_CPYW;
                end
                S_CPYW: begin
                    if (j_last) begin
                        r_bvalid[r_rem] <= 1'b1;
                        r_count         <= r_count + CNT_W'(1);
                        r_res_status    <= sid_pkg::ST_INSERTED;
                        r_res_id        <= r_count + CNT_W'(1);
                        r_state         <= S_DONE;
                    end else begin
                        r_j     <= r_j + LEN_W'(1);
                        r_state <= S_CPY;
                    end
                end
                S_DONE: begin
                    // load the output word once the register is free
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        o_status    <= r_res_status;
                        o_key_id    <= r_res_id;
                        o_key_count <= r_count;
                        r_state     <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    // checks on the sequencer
    `SID_ASSERT_NEVER(a_count_max, i_clk, i_rst_n, r_count > EMPTY)
    `SID_ASSERT_IMP(a_chain_written, i_clk, i_rst_n, walk_live, r_cur < r_count)
    `SID_ASSERT_IMP(a_cmp_in_key, i_clk, i_rst_n, byte_step, r_j < r_klen)
    `SID_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, meta_we, r_count == $past(r_count) + 1'b1)
endmodule

[test/string_id_dictionary_tb.sv]
// self-checking testbench for the string id dictionary
`timescale 1ns / 100ps

module string_id_dictionary_tb;
    localparam int MAX_ENTRIES   = 256;
    localparam int MAX_KEY_BYTES = 64;
    localparam int CNT_W         = 9;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        sid_pkg::t_status status;
        logic [CNT_W-1:0] id;
        logic [CNT_W-1:0] count;
    } t_answer;

    typedef byte unsigned t_key[$];

    // scoreboard: dictionary predictor plus queue of expected answers
    class dict_scoreboard;
        t_key           stored[$];
        logic [31:0]    lo, hi;
        byte unsigned   pend[$];
        bit             overflow;
        t_answer        answers[$];
        int             mismatches;

        function void clear_key();
            pend.delete();
            overflow = 0;
            lo = 1;
            hi = 0;
        endfunction

        function bit same_key(t_key a, t_key b);
            if (a.size() != b.size()) return 0;
            foreach (a[i]) if (a[i] != b[i]) return 0;
            return 1;
        endfunction

        // stored keys are unique and equal keys share a bucket, so a plain search is exact
        function int find_slot();
            for (int s = 0; s < stored.size(); s++) begin
                if (same_key(stored[s], pend)) return s;
            end
            return -1;
        endfunction

        // take one accepted input word
        function void note_word(logic op, byte unsigned b, logic last);
            int hit;
            t_answer a;
            lo = (lo + b) % 65521;
            hi = (hi + lo) % 65521;
            if (pend.size() < MAX_KEY_BYTES) pend.push_back(b);
            else overflow = 1;
            if (!last) return;
            a.id = 0;
            if (overflow) begin
                a.status = sid_pkg::ST_TOO_LONG;
            end else begin
                hit = find_slot();
                if (op == sid_pkg::OP_LOOKUP) begin
                    a.status = (hit >= 0) ? sid_pkg::ST_FOUND : sid_pkg::ST_NOT_FOUND;
                    if (hit >= 0) a.id = CNT_W'(hit + 1);
                end else if (hit >= 0) begin
                    a.status = sid_pkg::ST_DUPLICATE;
                    a.id = CNT_W'(hit + 1);
                end else if (stored.size() >= MAX_ENTRIES) begin
                    a.status = sid_pkg::ST_FULL;
                end else begin
                    stored.push_back(pend);
                    a.status = sid_pkg::ST_INSERTED;
                    a.id = CNT_W'(stored.size());
                end
            end
            a.count = CNT_W'(stored.size());
            answers.push_back(a);
            clear_key();
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(sid_pkg::t_status st, logic [CNT_W-1:0] id,
                                 logic [CNT_W-1:0] cnt);
            t_answer e;
            if (answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d id=%0d", st, id);
                return;
            end
            e = answers.pop_front();
            if (e.status !== st || e.id !== id || e.count !== cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d id=%0d cnt=%0d got st=%0d id=%0d cnt=%0d",
                             e.status, e.id, e.count, st, id, cnt);
            end
        endfunction
    endclass

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             i_in_valid = 0;
    logic             o_in_ready;
    logic             i_operation = 0;
    logic [7:0]       i_key_byte = 0;
    logic             i_key_last = 0;
    logic             o_out_valid;
    logic             i_out_ready = 0;
    sid_pkg::t_status o_status;
    logic [CNT_W-1:0] o_key_id;
    logic [CNT_W-1:0] o_key_count;

    dict_scoreboard sb;
    int  send_idle_pct, recv_stall_pct;
    bit  hold_off;
    int  cycles;
    t_key pool[$];

    string_id_dictionary dut (.*);

    always #2 i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_status, o_key_id, o_key_count);
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // drive one word and wait until it is taken; valid stays up for the next word
    task automatic send_word(logic op, byte unsigned b, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_operation <= op;
        i_key_byte  <= b;
        i_key_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(op, b, last);
    endtask

    task automatic send_key(logic op, t_key k);
        foreach (k[i]) send_word(op, k[i], i == k.size() - 1);
    endtask

    function automatic t_key rand_key(int len);
        t_key k;
        for (int i = 0; i < len; i++) k.push_back(8'($urandom_range(255)));
        return k;
    endfunction

    // mostly short keys, occasionally at or over the length limit
    function automatic int rand_len();
        int r = $urandom_range(99);
        if (r < 3) return $urandom_range(MAX_KEY_BYTES + 1, MAX_KEY_BYTES + 3);
        if (r < 6) return MAX_KEY_BYTES;
        return $urandom_range(1, 4);
    endfunction

    task automatic random_phase(int nkeys);
        t_key k;
        logic op;
        for (int n = 0; n < nkeys; n++) begin
            if (pool.size() > 0 && $urandom_range(1)) k = pool[$urandom_range(pool.size() - 1)];
            else k = rand_key(rand_len());
            op = 1'($urandom_range(1));
            if (k.size() <= MAX_KEY_BYTES && op == sid_pkg::OP_INSERT) pool.push_back(k);
            send_key(op, k);
        end
    endtask

    initial begin
        t_key k;
        sb = new();
        sb.clear_key();
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, both operations, special cases
        k = {8'h00};            send_key(sid_pkg::OP_LOOKUP, k);
        send_key(sid_pkg::OP_INSERT, k);
        send_key(sid_pkg::OP_INSERT, k);
        send_key(sid_pkg::OP_LOOKUP, k);
        k = {8'hff};            send_key(sid_pkg::OP_INSERT, k);
        k = {8'h55, 8'haa};     send_key(sid_pkg::OP_INSERT, k);
        k = {8'haa, 8'h55};     send_key(sid_pkg::OP_LOOKUP, k);
        k = rand_key(MAX_KEY_BYTES);
        send_key(sid_pkg::OP_INSERT, k);
        send_key(sid_pkg::OP_LOOKUP, k);
        k = rand_key(MAX_KEY_BYTES + 1);
        send_key(sid_pkg::OP_INSERT, k);
        send_key(sid_pkg::OP_LOOKUP, k);

        // phases of idling; long receiver hold-off in the first
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(20);
        join
        send_idle_pct = 52; recv_stall_pct = 0;  random_phase(20);
        send_idle_pct = 0;  recv_stall_pct = 52; random_phase(20);
        send_idle_pct = 9;  recv_stall_pct = 9;  random_phase(20);

        // fill the table with one-byte keys, then probe full behavior
        send_idle_pct = 0;  recv_stall_pct = 0;
        for (int b = 0; b < 256 && sb.stored.size() < MAX_ENTRIES; b++) begin
            k.delete();
            k.push_back(8'(b));
            send_key(sid_pkg::OP_INSERT, k);
        end
        k = rand_key(2); send_key(sid_pkg::OP_INSERT, k);
        send_key(sid_pkg::OP_LOOKUP, sb.stored[0]);
        send_key(sid_pkg::OP_INSERT, sb.stored[MAX_ENTRIES - 1]);
        random_phase(5);
        i_in_valid <= 0;

        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
